FILE: rtl/prsa_pkg.sv
// ----------------------------------------------------------------------------
// prsa_pkg
// Types and codes shared by the seat allocator, its channels and its store.
// ----------------------------------------------------------------------------
package prsa_pkg;

  // Opcodes of an input item
  localparam logic OpAdd   = 1'b0;
  localparam logic OpServe = 1'b1;

  // Result status codes
  localparam logic [1:0] StatusDone  = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  // Width of seat numbers and of the seat register
  localparam int unsigned SeatW = 7;

  typedef struct packed {
    logic        opcode;
    logic [15:0] requester_id;
    logic [7:0]  request_priority;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] served_id;
    logic [7:0]  served_priority;
    logic [6:0]  seat_number;
    logic        waitlisted;
    logic [5:0]  pending_count;
  } res_t;

  // One stored request
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
  } entry_t;

endpackage

FILE: rtl/prsa_stream_if.sv
// ----------------------------------------------------------------------------
// prsa_stream_if
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface prsa_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/prsa_ram.sv
// ----------------------------------------------------------------------------
// prsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/priority_request_seat_allocator.sv
// ----------------------------------------------------------------------------
// priority_request_seat_allocator
// Holds up to QUEUE_DEPTH booking requests in arrival order. An add item
// stores a request (status full when no room); a serve item removes the
// highest-priority request, the earliest on a tie, and books the lowest free
// seat within the configured seat limit, or waitlists it. Requests live in
// a single RAM with one read and one write port. An add is stored as it is
// accepted; a serve is accepted, sweeps the stored requests to find the best
// one, closes the gap by moving each later entry down one place and then
// finishes. A result that is still held in the output register stalls the
// finish state until it has been taken. The input is not ready while an item
// is at work. Seats are never released, so the taken seats always form a run
// from seat one and a single count stands for the seat map; it is cleared by
// reset.
// ----------------------------------------------------------------------------
module priority_request_seat_allocator #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned SEAT_COUNT  = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  prsa_stream_if.sink                 req_i,
  prsa_stream_if.source               res_o,
  input  logic                        cfg_we_i,
  input  logic [prsa_pkg::SeatW-1:0]  cfg_wdata_i
);

  localparam int unsigned AddrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CountW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SeatMax = (1 << prsa_pkg::SeatW) - 1;
  localparam int unsigned SeatCap = (SEAT_COUNT > SeatMax) ? SeatMax : SEAT_COUNT;
  localparam logic [prsa_pkg::SeatW-1:0] SeatCapW = prsa_pkg::SeatW'(SeatCap);
  localparam logic [CountW-1:0] DepthW = CountW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StShift,
    StFinish
  } state_e;

  state_e                      state_q;
  logic [CountW-1:0]           cnt_q;
  logic [CountW-1:0]           idx_q;
  logic                        vld_q;
  logic [AddrW-1:0]            tag_q;
  logic [AddrW-1:0]            best_q;
  prsa_pkg::entry_t            best_ent_q;
  logic [prsa_pkg::SeatW-1:0]  seats_cfg_q;
  logic [prsa_pkg::SeatW-1:0]  booked_q;
  prsa_pkg::res_t              res_q;
  prsa_pkg::res_t              out_q;
  logic                        out_v_q;

  logic                        issue;
  logic                        ram_we;
  logic [AddrW-1:0]            ram_waddr;
  prsa_pkg::entry_t            ram_wdata;
  prsa_pkg::entry_t            ram_rdata;
  logic [prsa_pkg::SeatW-1:0]  seat_limit;
  logic                        accept;
  logic                        out_free;

  // Request store
  prsa_ram #(
    .Width ($bits(prsa_pkg::entry_t)),
    .Depth (QUEUE_DEPTH),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign res_o.valid = out_v_q;
  assign res_o.data  = out_q;
  assign out_free    = !out_v_q || res_o.ready;
  assign seat_limit  = (seats_cfg_q > SeatCapW) ? SeatCapW : seats_cfg_q;

  // Store port control: read sweep, append on add, gap closing on serve
  always_comb begin
    issue     = ((state_q == StScan) || (state_q == StShift)) && (idx_q < cnt_q);
    ram_we    = 1'b0;
    ram_waddr = cnt_q[AddrW-1:0];
    ram_wdata = '{id: req_i.data.requester_id, prio: req_i.data.request_priority};
    if (accept && (req_i.data.opcode == prsa_pkg::OpAdd) && (cnt_q < DepthW)) begin
      ram_we = 1'b1;
    end else if ((state_q == StShift) && vld_q) begin
      ram_we    = 1'b1;
      ram_waddr = tag_q - AddrW'(1);
      ram_wdata = ram_rdata;
    end
  end

  // Sequencer, counts and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      vld_q       <= 1'b0;
      tag_q       <= '0;
      best_q      <= '0;
      best_ent_q  <= '0;
      seats_cfg_q <= prsa_pkg::SeatW'(64);
      booked_q    <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_v_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seats_cfg_q <= cfg_wdata_i;
      end
      // Output register: loaded from the finish state, cleared on transfer
      if ((state_q == StFinish) && out_free) begin
        out_q   <= res_q;
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
      vld_q <= issue;
      tag_q <= idx_q[AddrW-1:0];
      if (issue) begin
        idx_q <= idx_q + CountW'(1);
      end

      unique case (state_q)
        StIdle: begin
          if (accept) begin
            if (req_i.data.opcode == prsa_pkg::OpAdd) begin
              if (cnt_q < DepthW) begin
                cnt_q <= cnt_q + CountW'(1);
                res_q <= '{status: prsa_pkg::StatusDone, served_id: 16'd0,
                           served_priority: 8'd0, seat_number: 7'd0, waitlisted: 1'b0,
                           pending_count: 6'(cnt_q + CountW'(1))};
              end else begin
                res_q <= '{status: prsa_pkg::StatusFull, served_id: 16'd0,
                           served_priority: 8'd0, seat_number: 7'd0, waitlisted: 1'b0,
                           pending_count: 6'(cnt_q)};
              end
              state_q <= StFinish;
            end else if (cnt_q == '0) begin
              res_q   <= '{status: prsa_pkg::StatusEmpty, served_id: 16'd0,
                           served_priority: 8'd0, seat_number: 7'd0, waitlisted: 1'b0,
                           pending_count: 6'd0};
              state_q <= StFinish;
            end else begin
              idx_q   <= '0;
              state_q <= StScan;
            end
          end
        end

        StScan: begin
          // strict compare keeps the earliest entry on equal priority
          if (vld_q && ((tag_q == '0) || (ram_rdata.prio > best_ent_q.prio))) begin
            best_q     <= tag_q;
            best_ent_q <= ram_rdata;
          end
          if (!issue && !vld_q) begin
            idx_q   <= CountW'(best_q) + CountW'(1);
            state_q <= StShift;
          end
        end

        StShift: begin
          if (!issue && !vld_q) begin
            cnt_q                 <= cnt_q - CountW'(1);
            res_q.status          <= prsa_pkg::StatusDone;
            res_q.served_id       <= best_ent_q.id;
            res_q.served_priority <= best_ent_q.prio;
            res_q.pending_count   <= 6'(cnt_q - CountW'(1));
            if (booked_q < seat_limit) begin
              booked_q          <= booked_q + prsa_pkg::SeatW'(1);
              res_q.seat_number <= booked_q + prsa_pkg::SeatW'(1);
              res_q.waitlisted  <= 1'b0;
            end else begin
              res_q.seat_number <= '0;
              res_q.waitlisted  <= 1'b1;
            end
            state_q <= StFinish;
          end
        end

        StFinish: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end

        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

FILE: bench/tb_priority_request_seat_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_request_seat_allocator
// Self-checking bench for the seat allocator. A driver feeds add and serve
// items from a queue, a monitor compares every result with the outcome worked
// out by a behavioural model of the request store and the seat map. Phases
// run under different seat limits, with random idling on both channels in all
// but the last phase, a long result hold-off and an all-idle pause before each register write.
// ----------------------------------------------------------------------------
module tb_priority_request_seat_allocator;

  localparam int unsigned StoreDepth  = 32;
  localparam int unsigned SeatTotal   = 64;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned DrainCycles = 150;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [prsa_pkg::SeatW-1:0]    cfg_wdata;

  prsa_stream_if #(.T(prsa_pkg::req_t)) req_if ();
  prsa_stream_if #(.T(prsa_pkg::res_t)) res_if ();

  priority_request_seat_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Model state: waiting requests in arrival order, seat map, seat limit
  prsa_pkg::entry_t     waiting_requests[$];
  bit [SeatTotal-1:0]   seat_booked = '0;
  int unsigned          seat_limit  = 64;

  prsa_pkg::req_t       pending_items[$];
  prsa_pkg::res_t       booking_outcomes_due[$];
  prsa_pkg::res_t       due;
  int unsigned          mismatches   = 0;
  int unsigned          results_seen = 0;
  int unsigned          idle_cycles  = 0;
  int unsigned          send_gap     = 0;
  int unsigned          stall_left   = 0;
  int unsigned          hold_left    = 0;
  bit                   idling_on    = 1'b1;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Outcome of one item on the model state
  function automatic prsa_pkg::res_t predict_booking_outcome(prsa_pkg::req_t item);
    prsa_pkg::res_t   outcome;
    prsa_pkg::entry_t fresh;
    int unsigned      best;
    int unsigned      limit;
    outcome = '0;
    if (item.opcode == prsa_pkg::OpAdd) begin
      if (waiting_requests.size() >= StoreDepth) begin
        outcome.status = prsa_pkg::StatusFull;
      end else begin
        fresh = '{id: item.requester_id, prio: item.request_priority};
        waiting_requests.insert(waiting_requests.size(), fresh);
        outcome.status = prsa_pkg::StatusDone;
      end
    end else if (waiting_requests.size() == 0) begin
      outcome.status = prsa_pkg::StatusEmpty;
    end else begin
      // highest priority, earliest on a tie
      best = 0;
      for (int unsigned i = 1; i < waiting_requests.size(); i++) begin
        if (waiting_requests[i].prio > waiting_requests[best].prio) best = i;
      end
      outcome.status          = prsa_pkg::StatusDone;
      outcome.served_id       = waiting_requests[best].id;
      outcome.served_priority = waiting_requests[best].prio;
      waiting_requests.delete(best);
      // lowest free seat within the limit, saturated at the seat total
      limit = (seat_limit > SeatTotal) ? SeatTotal : seat_limit;
      for (int unsigned s = 0; s < limit; s++) begin
        if (!seat_booked[s]) begin
          seat_booked[s]      = 1'b1;
          outcome.seat_number = prsa_pkg::SeatW'(s + 1);
          break;
        end
      end
      outcome.waitlisted = (outcome.seat_number == '0);
    end
    outcome.pending_count = 6'(waiting_requests.size());
    return outcome;
  endfunction

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: predicts on every accepted item, then offers the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        booking_outcomes_due.insert(booking_outcomes_due.size(),
                                    predict_booking_outcome(req_if.data));
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap == 0 && idling_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 3);
        end
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          req_if.valid <= 1'b1;
          req_if.data  <= pending_items.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer, drives ready with stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (booking_outcomes_due.size() == 0) begin
          $error("result transfer with no item outstanding");
          mismatches++;
        end else begin
          due = booking_outcomes_due.pop_front();
          compare_field("status",          due.status,          res_if.data.status);
          compare_field("served_id",       due.served_id,       res_if.data.served_id);
          compare_field("served_priority", due.served_priority, res_if.data.served_priority);
          compare_field("seat_number",     due.seat_number,     res_if.data.seat_number);
          compare_field("waitlisted",      due.waitlisted,      res_if.data.waitlisted);
          compare_field("pending_count",   due.pending_count,   res_if.data.pending_count);
        end
        results_seen++;
        // long hold-off so the block fills up and stalls its input
        if (results_seen == 250 || results_seen == 900) hold_left = 120;
      end
      if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic queue_item(logic op, logic [15:0] id, logic [7:0] prio);
    prsa_pkg::req_t item;
    item = '{opcode: op, requester_id: id, request_priority: prio};
    pending_items.insert(pending_items.size(), item);
  endtask

  // Wait until nothing is in flight
  task automatic wait_all_done();
    while (pending_items.size() != 0 || req_if.valid || booking_outcomes_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Register write, only with the block idle
  task automatic set_seat_limit(logic [prsa_pkg::SeatW-1:0] value);
    wait_all_done();
    cfg_we     <= 1'b1;
    cfg_wdata  <= value;
    seat_limit = value;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
  endtask

  task automatic run_booking_phase(int unsigned count, int unsigned add_pct);
    logic        op;
    logic [15:0] id;
    logic [7:0]  prio;
    for (int unsigned n = 0; n < count; n++) begin
      op = ($urandom_range(0, 99) < add_pct) ? prsa_pkg::OpAdd : prsa_pkg::OpServe;
      id = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                        : 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 3))
        0:       prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        1:       prio = 8'($urandom_range(100, 103));   // dense band for ties
        default: prio = 8'($urandom_range(0, 255));
      endcase
      queue_item(op, id, prio);
    end
  endtask

  // Stimulus
  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    res_if.ready  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No seats: every serve waitlisted; extremes, ties, serve on empty store
    set_seat_limit(0);
    queue_item(prsa_pkg::OpServe, 16'hFFFF, 8'hFF);
    queue_item(prsa_pkg::OpAdd,   16'h0000, 8'h00);
    queue_item(prsa_pkg::OpAdd,   16'hFFFF, 8'hFF);
    queue_item(prsa_pkg::OpAdd,   16'h1234, 8'hFF);
    queue_item(prsa_pkg::OpAdd,   16'hABCD, 8'h80);
    repeat (4) queue_item(prsa_pkg::OpServe, 16'h5A5A, 8'hA5);
    queue_item(prsa_pkg::OpServe, 16'h0000, 8'h00);

    // Three seats: bookings then waitlist once they are gone
    set_seat_limit(3);
    for (int unsigned k = 0; k < 5; k++) begin
      queue_item(prsa_pkg::OpAdd, 16'(16'h0100 + k), 8'(7));
    end
    repeat (5) queue_item(prsa_pkg::OpServe, 16'h0000, 8'h00);

    // Random phases under a range of seat limits
    set_seat_limit(5);
    run_booking_phase(200, 55);
    set_seat_limit(1);                 // below the seats already taken
    run_booking_phase(150, 50);
    set_seat_limit(7'h7F);             // above the seat total, saturates
    run_booking_phase(400, 60);
    set_seat_limit(40);
    run_booking_phase(250, 85);        // fills the store and overflows it
    set_seat_limit(0);
    run_booking_phase(200, 35);        // drains it, serves on empty store
    set_seat_limit(64);
    idling_on = 1'b0;
    run_booking_phase(700, 50);

    wait_all_done();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && booking_outcomes_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
